FILE: hw/rtl/fcull_pkg.sv
// Shared types and constants for the frustum box cull block.
package fcull_pkg;

    localparam int unsigned NUM_PLANES = 6;
    localparam int unsigned NUM_ROWS   = 3;
    localparam int unsigned NUM_CFG    = 8;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned COEF_W     = 33;
    localparam int unsigned XSUM_W     = 66;
    localparam int unsigned PSUM_W     = 68;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_TEST = 1'b1;
    localparam logic [1:0] ROW_NONE = 2'd3;

    typedef struct packed {
        logic       load_row;
        logic       start;
        logic       issue;
        logic [2:0] corner;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic visible;
    } sts_t;

endpackage

FILE: hw/rtl/fcull_ctrl.sv
// Sequencer for the frustum box cull block: handshakes, corner issue, result register.
module fcull_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                action,
    input  logic [1:0]          row_index,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic                visible,
    output fcull_pkg::cmd_t     cmd,
    input  fcull_pkg::sts_t     sts
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_vis_reg, out_vis_next;
    logic       accept;
    logic       out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign visible  = out_vis_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        out_load     = 1'b0;
        cmd.load_row = accept && (action == fcull_pkg::ACTION_LOAD)
                       && (row_index != fcull_pkg::ROW_NONE);
        cmd.start    = accept && (action == fcull_pkg::ACTION_TEST);
        cmd.issue    = 1'b0;
        cmd.corner   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = 3'd0;
                if (cmd.start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
                cnt_next  = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN, ST_HOLD:
            begin
                if (!sts.busy)
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_vis_next   = out_vis_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_vis_next   = sts.visible;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_vis_reg <= out_vis_next;
    end

    a_issue_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (state_reg == ST_RUN))
        else $error("corner issued outside run state");

    a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("result overwrote an untaken result");

    a_run_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && cnt_reg == 3'd7) |=> (state_reg == ST_DRAIN))
        else $error("run did not end after eight corners");

endmodule

FILE: hw/rtl/fcull_dp.sv
// Datapath for the frustum box cull block: registers, corner transform, plane tests.
module fcull_dp
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  fcull_pkg::cmd_t        cmd,
    output fcull_pkg::sts_t        sts,
    input  logic [1:0]             row_index,
    input  logic [191:0]           words,
    input  logic                   cfg_we,
    input  logic [fcull_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data
);

    localparam int XW = fcull_pkg::XSUM_W;
    localparam int PW = fcull_pkg::PSUM_W;
    localparam int CW = fcull_pkg::COEF_W;
    localparam logic signed [XW-1:0] SAT_MAX = XW'(64'sh7fffffff);
    localparam logic signed [XW-1:0] SAT_MIN = -XW'(64'sh80000000);
    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    logic [63:0]        cfg_reg   [fcull_pkg::NUM_CFG];
    logic signed [31:0] model_reg [3][4];
    logic signed [CW-1:0] coef_reg [6][4];
    logic signed [31:0] lo_reg [3];
    logic signed [31:0] hi_reg [3];
    logic signed [63:0] xp_reg [3][3];
    logic signed [31:0] pt_reg [3];
    logic signed [64:0] pp_reg [6][3];
    logic [5:0]         any_reg;
    logic               s1_reg, s2_reg, s3_reg;

    logic signed [31:0] corner [3];
    logic signed [XW-1:0] xsum [3];
    logic signed [XW-1:0] xfl  [3];
    logic signed [31:0] xsat [3];
    logic signed [PW-1:0] psum [6];
    logic [5:0]         pos;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            corner[j] = cmd.corner[j] ? hi_reg[j] : lo_reg[j];
        end
        for (int r = 0; r < 3; r++)
        begin
            xsum[r] = XW'(xp_reg[r][0]) + XW'(xp_reg[r][1]) + XW'(xp_reg[r][2])
                      + (XW'(model_reg[r][3]) <<< FRAC_BITS);
            xfl[r]  = xsum[r] >>> FRAC_BITS;
            if (xfl[r] > SAT_MAX)
            begin
                xsat[r] = 32'sh7fffffff;
            end
            else if (xfl[r] < SAT_MIN)
            begin
                xsat[r] = 32'sh80000000;
            end
            else
            begin
                xsat[r] = xfl[r][31:0];
            end
        end
        for (int p = 0; p < 6; p++)
        begin
            psum[p] = PW'(pp_reg[p][0]) + PW'(pp_reg[p][1]) + PW'(pp_reg[p][2])
                      + (PW'(coef_reg[p][3]) <<< FRAC_BITS);
            pos[p]  = !psum[p][PW-1] && (psum[p] != '0);
        end
    end

    assign sts.busy    = s1_reg || s2_reg || s3_reg;
    assign sts.visible = &any_reg;

    // configuration and model transform, identity after reset; stage flags, plane hits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[0] <= 64'(ONE);
            cfg_reg[1] <= 64'd0;
            cfg_reg[2] <= {ONE, 32'd0};
            cfg_reg[3] <= 64'd0;
            cfg_reg[4] <= 64'd0;
            cfg_reg[5] <= 64'(ONE);
            cfg_reg[6] <= 64'd0;
            cfg_reg[7] <= {ONE, 32'd0};
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    model_reg[r][c] <= (r == c) ? ONE : 32'd0;
                end
            end
            s1_reg  <= 1'b0;
            s2_reg  <= 1'b0;
            s3_reg  <= 1'b0;
            any_reg <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index < fcull_pkg::CFG_IDX_W'(fcull_pkg::NUM_CFG)))
            begin
                cfg_reg[cfg_index[2:0]] <= cfg_data;
            end
            if (cmd.load_row)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    model_reg[row_index][c] <= words[c*32 +: 32];
                end
            end
            s1_reg <= cmd.issue;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            if (cmd.start)
            begin
                any_reg <= '0;
            end
            else if (s3_reg)
            begin
                any_reg <= any_reg | pos;
            end
        end
    end

    // plane coefficients registered from the matrix columns, box bounds and pipeline products
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            coef_reg[0][i] <= CW'($signed(cfg_reg[2*i+1][63:32])) + CW'($signed(cfg_reg[2*i][31:0]));
            coef_reg[1][i] <= CW'($signed(cfg_reg[2*i+1][63:32])) - CW'($signed(cfg_reg[2*i][31:0]));
            coef_reg[2][i] <= CW'($signed(cfg_reg[2*i+1][63:32])) - CW'($signed(cfg_reg[2*i][63:32]));
            coef_reg[3][i] <= CW'($signed(cfg_reg[2*i+1][63:32])) + CW'($signed(cfg_reg[2*i][63:32]));
            coef_reg[4][i] <= CW'($signed(cfg_reg[2*i+1][63:32])) + CW'($signed(cfg_reg[2*i+1][31:0]));
            coef_reg[5][i] <= CW'($signed(cfg_reg[2*i+1][63:32])) - CW'($signed(cfg_reg[2*i+1][31:0]));
        end
        if (cmd.start)
        begin
            for (int j = 0; j < 3; j++)
            begin
                lo_reg[j] <= words[j*32 +: 32];
                hi_reg[j] <= words[(j+3)*32 +: 32];
            end
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                xp_reg[r][j] <= model_reg[r][j] * corner[j];
            end
            pt_reg[r] <= xsat[r];
        end
        for (int p = 0; p < 6; p++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pp_reg[p][j] <= coef_reg[p][j] * 65'(pt_reg[j]);
            end
        end
    end

endmodule

FILE: hw/rtl/frustum_box_cull_core.sv
// Top level of the frustum box cull block: controller and datapath.
//
// Input stream (s_*): tdata carries word0..word5, tuser carries action and
// row_index. A load item (action 0) writes one model transform row in the
// cycle it is accepted and gives no result; row index three is dropped.
// A test item (action 1) gives one result on the output stream (m_*):
// visible in tdata bit 0. The eight box corners issue one per cycle through
// a four-stage transform and plane-product pipeline. Input is taken only
// between tests, so the next item can be accepted in the cycle after a
// result is loaded into the output register.
// A stalled receiver holds the result in the output register; the next test
// runs but waits for the held result to be taken before finishing.
// Configuration (cfg_*): write matrix column registers 0..7 while idle;
// indexes eight and up are dropped. cfg_ready is always high.
// Reset: identity matrix and identity model transform, no result pending.
module frustum_box_cull_core
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // word0, word1, word2, word3, word4, word5
    input  logic [2:0]   s_tuser,   // action, row_index
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // visible, zero fill
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [fcull_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]  cfg_data
);

    fcull_pkg::cmd_t cmd;
    fcull_pkg::sts_t sts;
    logic            visible;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {7'd0, visible};

    fcull_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .action    (s_tuser[0]),
        .row_index (s_tuser[2:1]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .visible   (visible),
        .cmd       (cmd),
        .sts       (sts)
    );

    fcull_dp #(.FRAC_BITS(FRAC_BITS)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .row_index (s_tuser[2:1]),
        .words     (s_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

FILE: dv/frustum_box_cull_checker.sv
// Checker for the frustum box cull block: predicts visibility and compares results.
module frustum_box_cull_checker
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [191:0] s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [7:0]   m_tdata,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [fcull_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]  cfg_data,
    output int           fail_count,
    output int           pending_count,
    output int           visible_seen,
    output int           culled_seen
);

    logic [63:0]          mtx_regs [fcull_pkg::NUM_CFG];
    logic signed [31:0]   xform [fcull_pkg::NUM_ROWS][4];
    logic                 visible_q [$];

    // floor by 2^FRAC_BITS, saturate to signed 32 bits
    function automatic logic signed [31:0] floor_clip(input logic signed [99:0] v);
        logic signed [99:0] q;
        begin
            q = v >>> FRAC_BITS;
            if (q > 100'sd2147483647)
                return 32'sh7fffffff;
            if (q < -100'sd2147483648)
                return 32'sh80000000;
            return q[31:0];
        end
    endfunction

    function automatic logic predict_visible(input logic [191:0] box);
        logic signed [31:0]  lo [3];
        logic signed [31:0]  hi [3];
        logic signed [31:0]  corner [8][3];
        logic signed [32:0]  coef [fcull_pkg::NUM_PLANES][4];
        logic signed [31:0]  cx, cy, cz, px, py, pz, pw;
        logic signed [99:0]  acc;
        logic                any_pos;
        logic                vis;
        begin
            for (int k = 0; k < 3; k++)
            begin
                lo[k] = box[32*k +: 32];
                hi[k] = box[32*(k+3) +: 32];
            end
            for (int i = 0; i < 4; i++)
            begin
                px = mtx_regs[2*i][31:0];
                py = mtx_regs[2*i][63:32];
                pz = mtx_regs[2*i+1][31:0];
                pw = mtx_regs[2*i+1][63:32];
                coef[0][i] = 33'(pw) + 33'(px);
                coef[1][i] = 33'(pw) - 33'(px);
                coef[2][i] = 33'(pw) - 33'(py);
                coef[3][i] = 33'(pw) + 33'(py);
                coef[4][i] = 33'(pw) + 33'(pz);
                coef[5][i] = 33'(pw) - 33'(pz);
            end
            for (int k = 0; k < 8; k++)
            begin
                cx = k[0] ? hi[0] : lo[0];
                cy = k[1] ? hi[1] : lo[1];
                cz = k[2] ? hi[2] : lo[2];
                for (int r = 0; r < 3; r++)
                begin
                    acc = 100'(xform[r][0]) * 100'(cx) + 100'(xform[r][1]) * 100'(cy)
                        + 100'(xform[r][2]) * 100'(cz) + (100'(xform[r][3]) <<< FRAC_BITS);
                    corner[k][r] = floor_clip(acc);
                end
            end
            vis = 1'b1;
            for (int p = 0; p < fcull_pkg::NUM_PLANES; p++)
            begin
                any_pos = 1'b0;
                for (int k = 0; k < 8; k++)
                begin
                    acc = 100'(coef[p][0]) * 100'(corner[k][0])
                        + 100'(coef[p][1]) * 100'(corner[k][1])
                        + 100'(coef[p][2]) * 100'(corner[k][2])
                        + (100'(coef[p][3]) <<< FRAC_BITS);
                    if (acc > 0)
                        any_pos = 1'b1;
                end
                if (!any_pos)
                    vis = 1'b0;
            end
            return vis;
        end
    endfunction

    assign pending_count = visible_q.size();

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtx_regs[0] <= 64'd65536;
            mtx_regs[1] <= 64'd0;
            mtx_regs[2] <= 64'd65536 << 32;
            mtx_regs[3] <= 64'd0;
            mtx_regs[4] <= 64'd0;
            mtx_regs[5] <= 64'd65536;
            mtx_regs[6] <= 64'd0;
            mtx_regs[7] <= 64'd65536 << 32;
            for (int r = 0; r < fcull_pkg::NUM_ROWS; r++)
                for (int c = 0; c < 4; c++)
                    xform[r][c] <= (r == c) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
            visible_q.delete();
            fail_count   <= 0;
            visible_seen <= 0;
            culled_seen  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && cfg_index < fcull_pkg::NUM_CFG)
                mtx_regs[cfg_index[2:0]] <= cfg_data;
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == fcull_pkg::ACTION_TEST)
                    visible_q.push_back(predict_visible(s_tdata));
                else if (s_tuser[2:1] != fcull_pkg::ROW_NONE)
                    for (int c = 0; c < 4; c++)
                        xform[s_tuser[2:1]][c] <= s_tdata[32*c +: 32];
            end
            if (m_tvalid && m_tready)
            begin
                if (visible_q.size() == 0)
                begin
                    $error("visible: unexpected result, actual %0d", m_tdata[0]);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (m_tdata[0] !== visible_q[0] || m_tdata[7:1] !== 7'd0)
                    begin
                        if (m_tdata[0] !== visible_q[0])
                            $error("visible: expected %0d, actual %0d",
                                   visible_q[0], m_tdata[0]);
                        if (m_tdata[7:1] !== 7'd0)
                            $error("zero fill: expected 0, actual %0h", m_tdata[7:1]);
                        fail_count <= fail_count + 1;
                    end
                    if (visible_q[0])
                        visible_seen <= visible_seen + 1;
                    else
                        culled_seen <= culled_seen + 1;
                    void'(visible_q.pop_front());
                end
            end
        end
    end

endmodule

FILE: dv/tb.sv
// Testbench top: stimulus, stalls, configuration phases and verdict for the cull block.
module tb;

    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic signed [31:0] ONE = 32'sd65536;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [7:0]   m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [fcull_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]  cfg_data = '0;

    int  fail_count, pending_count, visible_seen, culled_seen;
    int  items_sent = 0;
    int  idle_cycles = 0;
    bit  long_stall = 1'b0;
    bit  stim_done = 1'b0;

    always #5 clk = ~clk;

    frustum_box_cull_core u_top (.*);

    frustum_box_cull_checker u_chk (.*);

    // Count cycles with no handshake on any channel; give up at the limit.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random backpressure per result, plus one long hold-off on request.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (long_stall)
            begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                long_stall = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // Offer one item, after a random gap unless no_gap is set, and hold it until accepted.
    task automatic send_item(input logic act, input logic [1:0] row,
                             input logic [191:0] words, input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {row, act};
        s_tdata  <= words;
        do @(posedge clk); while (!(s_tvalid && s_tready));
        items_sent++;
    endtask

    task automatic load_row(input logic [1:0] row, input logic signed [31:0] a,
                            input logic signed [31:0] b, input logic signed [31:0] c,
                            input logic signed [31:0] t);
        send_item(fcull_pkg::ACTION_LOAD, row,
                  {64'($urandom) << 32 | 64'($urandom), t, c, b, a});
    endtask

    task automatic test_box(input logic signed [31:0] x0, input logic signed [31:0] y0,
                            input logic signed [31:0] z0, input logic signed [31:0] x1,
                            input logic signed [31:0] y1, input logic signed [31:0] z1);
        send_item(fcull_pkg::ACTION_TEST, 2'd0 | 2'($urandom_range(0, 3)),
                  {z1, y1, x1, z0, y0, x0});
    endtask

    // Hold the sender until every expected result is back, then let the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [fcull_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return 32'sh80000000;
            2: return 32'sh7fffffff;
            default: return $signed($urandom_range(0, 4 << 16)) - (2 << 16);
        endcase
    endfunction

    // Random matrix column: mostly small values near one or zero, sometimes anything.
    function automatic logic [63:0] rand_col(input int col, input bit hi_half);
        logic signed [31:0] a, b;
        if ($urandom_range(0, 2) == 0)
            return {$urandom, $urandom};
        a = ((col == 2 * 0 + 0 && !hi_half) || (col == 1 && hi_half)) ? ONE : 0;
        b = $signed($urandom_range(0, 1 << 16)) - (1 << 15);
        return {32'(a + b), 32'($signed($urandom_range(0, 1 << 15)) - (1 << 14))};
    endfunction

    task automatic random_phase(input int count);
        logic signed [31:0] a, b;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 4) == 0)
                load_row(2'($urandom_range(0, 3)), rand_elem(), rand_elem(),
                         rand_elem(), rand_elem());
            else
            begin
                a = rand_coord();
                b = ($urandom_range(0, 5) == 0) ? rand_coord()
                    : a + $signed($urandom_range(0, 3 << 16));
                test_box(a, rand_coord(), rand_coord(), b, rand_coord(), rand_coord());
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset transform and matrix, boxes inside, outside, straddling.
        test_box(-ONE / 2, -ONE / 2, -ONE / 2, ONE / 2, ONE / 2, ONE / 2);
        test_box(3 * ONE, 3 * ONE, 3 * ONE, 4 * ONE, 4 * ONE, 4 * ONE);
        test_box(-4 * ONE, 0, 0, -2 * ONE, ONE / 4, ONE / 4);
        test_box(ONE / 2, -ONE, -ONE, 2 * ONE, ONE, ONE);
        test_box(ONE, 0, 0, 2 * ONE, 0, 0);                   // touches plane only
        test_box(ONE / 2, ONE / 2, ONE / 2, -ONE / 2, -ONE / 2, -ONE / 2); // inverted
        test_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
                 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        // Overflowing transform saturates the corners.
        load_row(2'd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        test_box(32'sh7fffffff, 0, 0, 32'sh7fffffff, 0, 0);
        load_row(2'd0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        test_box(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        // Row index three is dropped.
        load_row(fcull_pkg::ROW_NONE, 5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE);
        load_row(2'd0, ONE, 0, 0, 0);
        load_row(2'd1, 0, ONE, 0, 2 * ONE);
        load_row(2'd2, 0, 0, ONE, -ONE / 2);
        test_box(-ONE / 4, -ONE / 4, -ONE / 4, ONE / 4, ONE / 4, ONE / 4);
        test_box(0, -3 * ONE, 0, 0, -2 * ONE, 0);
        load_row(2'd1, 0, ONE, 0, 0);
        load_row(2'd2, 0, 0, ONE, 0);

        // Extreme matrix values, then two out of range indexes.
        drain();
        for (int i = 0; i < fcull_pkg::NUM_CFG; i++)
            write_reg(fcull_pkg::CFG_IDX_W'(i),
                      (i % 2) ? 64'h8000_0000_7fff_ffff : 64'h7fff_ffff_8000_0000);
        write_reg(fcull_pkg::CFG_IDX_W'(fcull_pkg::NUM_CFG), '0);
        write_reg(4'hf, '1);
        test_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
        test_box(32'sh80000000, 0, 32'sh7fffffff, 32'sh7fffffff, 0, 32'sh80000000);
        random_phase(30);

        // Phases of random matrices, then back to identity.
        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            for (int i = 0; i < fcull_pkg::NUM_CFG; i++)
                write_reg(fcull_pkg::CFG_IDX_W'(i), rand_col(i / 2, i % 2));
            random_phase(80);
        end

        // Receiver holds off while the sender keeps offering items.
        long_stall = 1'b1;
        for (int n = 0; n < 12; n++)
            test_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);

        drain();
        write_reg(fcull_pkg::CFG_IDX_W'(0), 64'd65536);
        write_reg(fcull_pkg::CFG_IDX_W'(1), 64'd0);
        write_reg(fcull_pkg::CFG_IDX_W'(2), 64'd65536 << 32);
        write_reg(fcull_pkg::CFG_IDX_W'(3), 64'd0);
        write_reg(fcull_pkg::CFG_IDX_W'(4), 64'd0);
        write_reg(fcull_pkg::CFG_IDX_W'(5), 64'd65536);
        write_reg(fcull_pkg::CFG_IDX_W'(6), 64'd0);
        write_reg(fcull_pkg::CFG_IDX_W'(7), 64'd65536 << 32);
        random_phase(60);

        drain();
        stim_done = 1'b1;
        $display("Covered %0d items across seven matrix settings, saturation and dropped rows.",
                 items_sent);
        $display("Results checked: %0d visible, %0d culled.", visible_seen, culled_seen);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: frustum_box_cull_core.f
hw/rtl/fcull_pkg.sv
hw/rtl/fcull_ctrl.sv
hw/rtl/fcull_dp.sv
hw/rtl/frustum_box_cull_core.sv
dv/frustum_box_cull_checker.sv
dv/tb.sv
